FILE: hw/rtl/sbph_pkg.sv
// Shared definitions for the spectrum bar / peak hold meter.
// Field widths, Q16 constants, register reset values, request codes and the
// store write-control struct. No dependencies.
package sbph_pkg;

  localparam int BandW   = 5;
  localparam int LevelW  = 19;
  localparam int Q16W    = 17;
  localparam int FracW   = 16;
  localparam int CfgIdxW = 2;

  localparam int BandCountDef = 32;

  localparam logic [Q16W-1:0] Q16_ONE = 17'h10000;

  localparam logic [Q16W-1:0] BAR_DECAY_RST  = 17'd58982;
  localparam logic [Q16W-1:0] PEAK_DECAY_RST = 17'd64225;
  localparam logic [Q16W-1:0] REST_DECAY_RST = 17'd52429;
  localparam logic [Q16W-1:0] REST_FLOOR_RST = 17'd66;

  typedef enum logic [1:0] {
    REQ_APPLY   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CLEAR   = 2'd2
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BAR_DECAY  = 2'd0,
    CFG_PEAK_DECAY = 2'd1,
    CFG_REST_DECAY = 2'd2,
    CFG_REST_FLOOR = 2'd3
  } cfg_idx_e;

  // Write control toward the band store.
  typedef struct packed {
    logic wr_en;    // write bar and peak of one band
    logic clr_all;  // drop every band to zero
  } wr_ctrl_t;

endpackage

FILE: hw/rtl/spectrum_bar_peak_hold.sv
// Top level of the spectrum bar / peak hold meter: request pipeline, forwarding,
// rest mask, floor sweep, registers and result stage.
// Depends on sbph_pkg, sbph_band_mem and sbph_update.
//
//   channel   direction  handshake                 payload
//   request   in         in_valid_i / in_stall_o   req_type_i, band_i, level_i
//   result    out        out_valid_o / out_stall_i bar_o, peak_o, at_rest_o
//   config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One request per cycle when no sweep runs and the output is not stalled. The
// band store's single read port sets the rate: one read-modify-write per
// cycle, with the last write forwarded to the next one.
// Reset clears the valid bits of the store, the rest mask and the pipeline.
// A write of rest_floor starts a sweep that rereads every band and rebuilds
// the rest mask; requests are stalled during it.
// A stalled result holds in the output register while one more request waits
// in the read stage.
module spectrum_bar_peak_hold
  import sbph_pkg::*;
#(
  parameter int BAND_COUNT = BandCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [BandW-1:0]   band_i,
  input  logic [LevelW-1:0]  level_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [Q16W-1:0]    bar_o,
  output logic [Q16W-1:0]    peak_o,
  output logic               at_rest_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [Q16W-1:0]    cfg_wdata_i
);

  localparam int IdxW = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int ExtW = (IdxW > BandW) ? IdxW : BandW;

  // Configuration registers
  logic [Q16W-1:0] bar_decay_q;
  logic [Q16W-1:0] peak_decay_q;
  logic [Q16W-1:0] rest_decay_q;
  logic [Q16W-1:0] rest_floor_q;

  // Read stage
  logic            s1_valid_q;
  req_e            s1_req_q;
  logic            s1_in_range_q;
  logic [IdxW-1:0] s1_addr_q;
  logic [Q16W-1:0] s1_level_q;

  // Last store write, forwarded into the read stage
  logic            fwd_vld_q;
  logic            fwd_clr_q;
  logic [IdxW-1:0] fwd_addr_q;
  logic [Q16W-1:0] fwd_bar_q;
  logic [Q16W-1:0] fwd_peak_q;

  // Rest mask and floor sweep
  logic [BAND_COUNT-1:0] mask_q;
  logic [BAND_COUNT-1:0] mask_d;
  logic                  sweep_act_q;
  logic                  sweep_chk_q;
  logic [IdxW-1:0]       sweep_cnt_q;
  logic [IdxW-1:0]       sweep_addr_q;

  // Result register
  logic            out_valid_q;
  logic [Q16W-1:0] bar_q;
  logic [Q16W-1:0] peak_q;
  logic            at_rest_q;

  logic            in_acc;
  logic            s1_adv;
  logic            sweep_busy;
  logic            floor_wr;
  logic [ExtW-1:0] band_ext;
  logic [IdxW-1:0] in_addr;
  logic            in_range;
  logic [Q16W-1:0] in_level;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [Q16W-1:0] rd_bar;
  logic [Q16W-1:0] rd_peak;
  logic            rd_vld;
  logic            fwd_hit;
  logic [Q16W-1:0] nxt_bar;
  logic [Q16W-1:0] nxt_peak;
  wr_ctrl_t        upd_wr;
  wr_ctrl_t        mem_wr;
  logic [Q16W-1:0] res_bar;
  logic [Q16W-1:0] res_peak;
  logic            upd_above;
  logic            sweep_above;

  // Handshake: hold requests while the sweep runs or the read stage is blocked.
  assign sweep_busy = sweep_act_q | sweep_chk_q;
  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = sweep_busy | (s1_valid_q & ~s1_adv);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign floor_wr   = cfg_we_i & (cfg_idx_e'(cfg_idx_i) == CFG_REST_FLOOR);

  // Decode the request: band range check and level clamp to 0..1.0.
  assign band_ext = ExtW'(band_i);
  assign in_addr  = band_ext[IdxW-1:0];
  assign in_range = 32'(band_i) < BAND_COUNT;

  always_comb begin
    if (level_i[LevelW-1]) begin
      in_level = '0;
    end else if (level_i[LevelW-2:0] > (LevelW-1)'(Q16_ONE)) begin
      in_level = Q16_ONE;
    end else begin
      in_level = level_i[Q16W-1:0];
    end
  end

  // Store read port: sweep owns it while running, requests otherwise.
  assign rd_en   = sweep_act_q | in_acc;
  assign rd_addr = sweep_act_q ? sweep_cnt_q : in_addr;

  assign mem_wr.wr_en   = upd_wr.wr_en & s1_adv;
  assign mem_wr.clr_all = upd_wr.clr_all & s1_adv;

  sbph_band_mem #(
    .BAND_COUNT(BAND_COUNT)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_ctrl_i (mem_wr),
    .wr_addr_i (s1_addr_q),
    .wr_bar_i  (nxt_bar),
    .wr_peak_i (nxt_peak),
    .rd_bar_o  (rd_bar),
    .rd_peak_o (rd_peak),
    .rd_vld_o  (rd_vld)
  );

  // The read of the request in the read stage missed only the latest write.
  assign fwd_hit = fwd_vld_q & (fwd_clr_q | (fwd_addr_q == s1_addr_q));

  sbph_update u_upd (
    .req_i        (s1_req_q),
    .in_range_i   (s1_in_range_q),
    .level_i      (s1_level_q),
    .rd_bar_i     (rd_bar),
    .rd_peak_i    (rd_peak),
    .rd_vld_i     (rd_vld),
    .fwd_hit_i    (fwd_hit),
    .fwd_clr_i    (fwd_clr_q),
    .fwd_bar_i    (fwd_bar_q),
    .fwd_peak_i   (fwd_peak_q),
    .bar_decay_i  (bar_decay_q),
    .peak_decay_i (peak_decay_q),
    .rest_decay_i (rest_decay_q),
    .nxt_bar_o    (nxt_bar),
    .nxt_peak_o   (nxt_peak),
    .wr_ctrl_o    (upd_wr),
    .res_bar_o    (res_bar),
    .res_peak_o   (res_peak)
  );

  // Rest mask: one bit per band above the floor; update the written band,
  // drop all on clear, rebuild one band per cycle during the sweep.
  assign upd_above   = (nxt_bar > rest_floor_q) | (nxt_peak > rest_floor_q);
  assign sweep_above = rd_vld & ((rd_bar > rest_floor_q) | (rd_peak > rest_floor_q));

  always_comb begin
    mask_d = mask_q;
    if (s1_adv) begin
      priority if (upd_wr.clr_all) begin
        mask_d = '0;
      end else if (upd_wr.wr_en) begin
        mask_d[s1_addr_q] = upd_above;
      end else begin
        // Hold the mask: unused request or band out of range.
        mask_d = mask_q;
      end
    end
    if (sweep_chk_q) begin
      mask_d[sweep_addr_q] = sweep_above;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_decay_q  <= BAR_DECAY_RST;
      peak_decay_q <= PEAK_DECAY_RST;
      rest_decay_q <= REST_DECAY_RST;
      rest_floor_q <= REST_FLOOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BAR_DECAY:  bar_decay_q  <= cfg_wdata_i;
        CFG_PEAK_DECAY: peak_decay_q <= cfg_wdata_i;
        CFG_REST_DECAY: rest_decay_q <= cfg_wdata_i;
        CFG_REST_FLOOR: rest_floor_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q      <= req_e'(req_type_i);
      s1_in_range_q <= in_range;
      s1_addr_q     <= in_addr;
      s1_level_q    <= in_level;
    end
  end

  // Forward register: track the latest store write or clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
      fwd_clr_q <= 1'b0;
    end else if (mem_wr.wr_en | mem_wr.clr_all) begin
      fwd_vld_q <= 1'b1;
      fwd_clr_q <= mem_wr.clr_all;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr.wr_en) begin
      fwd_addr_q <= s1_addr_q;
      fwd_bar_q  <= nxt_bar;
      fwd_peak_q <= nxt_peak;
    end
  end

  // Rest mask and sweep sequencing; a new floor write restarts the sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q       <= '0;
      sweep_act_q  <= 1'b0;
      sweep_chk_q  <= 1'b0;
      sweep_cnt_q  <= '0;
      sweep_addr_q <= '0;
    end else begin
      mask_q      <= mask_d;
      sweep_chk_q <= sweep_act_q;
      if (sweep_act_q) begin
        sweep_addr_q <= sweep_cnt_q;
      end
      if (floor_wr) begin
        sweep_act_q <= 1'b1;
        sweep_cnt_q <= '0;
      end else if (sweep_act_q) begin
        if (sweep_cnt_q == IdxW'(BAND_COUNT - 1)) begin
          sweep_act_q <= 1'b0;
        end else begin
          sweep_cnt_q <= sweep_cnt_q + 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      bar_q     <= res_bar;
      peak_q    <= res_peak;
      at_rest_q <= ~|mask_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bar_o       = bar_q;
  assign peak_o      = peak_q;
  assign at_rest_o   = at_rest_q;

endmodule

FILE: hw/rtl/sbph_band_mem.sv
// Band store: bar and peak memories with one registered read port, one write
// port and a valid bit per band. Depends on sbph_pkg.
module sbph_band_mem
  import sbph_pkg::*;
#(
  parameter int BAND_COUNT = BandCountDef,
  localparam int IdxW = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  input  wr_ctrl_t        wr_ctrl_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [Q16W-1:0] wr_bar_i,
  input  logic [Q16W-1:0] wr_peak_i,
  output logic [Q16W-1:0] rd_bar_o,
  output logic [Q16W-1:0] rd_peak_o,
  output logic            rd_vld_o
);

  logic [Q16W-1:0]       bar_mem  [BAND_COUNT];
  logic [Q16W-1:0]       peak_mem [BAND_COUNT];
  logic [BAND_COUNT-1:0] vld_q;
  logic [Q16W-1:0]       rd_bar_q;
  logic [Q16W-1:0]       rd_peak_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_ctrl_i.wr_en) begin
      bar_mem[wr_addr_i]  <= wr_bar_i;
      peak_mem[wr_addr_i] <= wr_peak_i;
    end
    if (rd_en_i) begin
      rd_bar_q  <= bar_mem[rd_addr_i];
      rd_peak_q <= peak_mem[rd_addr_i];
      rd_vld_q  <= vld_q[rd_addr_i];
    end
  end

  // Clear drops every valid bit; an invalid band reads as zero downstream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_ctrl_i.clr_all) begin
      vld_q <= '0;
    end else if (wr_ctrl_i.wr_en) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_bar_o  = rd_bar_q;
  assign rd_peak_o = rd_peak_q;
  assign rd_vld_o  = rd_vld_q;

endmodule

FILE: hw/rtl/sbph_update.sv
// Per-band update datapath: forward select, Q16 decays, bar jump and peak hold.
// Depends on sbph_pkg.
module sbph_update
  import sbph_pkg::*;
(
  input  req_e            req_i,
  input  logic            in_range_i,
  input  logic [Q16W-1:0] level_i,
  input  logic [Q16W-1:0] rd_bar_i,
  input  logic [Q16W-1:0] rd_peak_i,
  input  logic            rd_vld_i,
  input  logic            fwd_hit_i,
  input  logic            fwd_clr_i,
  input  logic [Q16W-1:0] fwd_bar_i,
  input  logic [Q16W-1:0] fwd_peak_i,
  input  logic [Q16W-1:0] bar_decay_i,
  input  logic [Q16W-1:0] peak_decay_i,
  input  logic [Q16W-1:0] rest_decay_i,
  output logic [Q16W-1:0] nxt_bar_o,
  output logic [Q16W-1:0] nxt_peak_o,
  output wr_ctrl_t        wr_ctrl_o,
  output logic [Q16W-1:0] res_bar_o,
  output logic [Q16W-1:0] res_peak_o
);

  function automatic logic [Q16W-1:0] q16_decay(input logic [Q16W-1:0] value,
                                                input logic [Q16W-1:0] factor);
    logic [Q16W-1:0]   f;
    logic [2*Q16W-1:0] prod;
    f    = (factor > Q16_ONE) ? Q16_ONE : factor;
    prod = (2*Q16W)'(value) * (2*Q16W)'(f);
    return prod[FracW+Q16W-1:FracW];
  endfunction

  logic [Q16W-1:0] cur_bar;
  logic [Q16W-1:0] cur_peak;
  logic [Q16W-1:0] f_bar;
  logic [Q16W-1:0] f_peak;
  logic [Q16W-1:0] dec_bar;
  logic [Q16W-1:0] dec_peak;
  logic [Q16W-1:0] new_bar;

  // Take the last write when it hit this band after the read was issued.
  always_comb begin
    if (fwd_hit_i) begin
      cur_bar  = fwd_clr_i ? '0 : fwd_bar_i;
      cur_peak = fwd_clr_i ? '0 : fwd_peak_i;
    end else begin
      cur_bar  = rd_vld_i ? rd_bar_i : '0;
      cur_peak = rd_vld_i ? rd_peak_i : '0;
    end
  end

  assign f_bar    = (req_i == REQ_APPLY) ? bar_decay_i : rest_decay_i;
  assign f_peak   = (req_i == REQ_APPLY) ? peak_decay_i : rest_decay_i;
  assign dec_bar  = q16_decay(cur_bar, f_bar);
  assign dec_peak = q16_decay(cur_peak, f_peak);
  assign new_bar  = (level_i > cur_bar) ? level_i : dec_bar;

  always_comb begin
    nxt_bar_o  = cur_bar;
    nxt_peak_o = cur_peak;
    wr_ctrl_o  = '0;
    unique case (req_i)
      REQ_APPLY: begin
        if (in_range_i) begin
          nxt_bar_o       = new_bar;
          nxt_peak_o      = (new_bar > dec_peak) ? new_bar : dec_peak;
          wr_ctrl_o.wr_en = 1'b1;
        end
      end
      REQ_RELEASE: begin
        if (in_range_i) begin
          nxt_bar_o       = dec_bar;
          nxt_peak_o      = dec_peak;
          wr_ctrl_o.wr_en = 1'b1;
        end
      end
      REQ_CLEAR: begin
        wr_ctrl_o.clr_all = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_bar_o  = (in_range_i && req_i != REQ_CLEAR) ? nxt_bar_o : '0;
  assign res_peak_o = (in_range_i && req_i != REQ_CLEAR) ? nxt_peak_o : '0;

endmodule

FILE: hw/rtl/sbph_checker.sv
// Port-level checks for the spectrum bar / peak hold meter, bound to the top.
// Depends on sbph_pkg and spectrum_bar_peak_hold.
module sbph_checker
  import sbph_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_i,
  input logic [1:0]       req_type_i,
  input logic             out_valid_i,
  input logic             out_stall_i,
  input logic [Q16W-1:0]  bar_i,
  input logic [Q16W-1:0]  peak_i,
  input logic             at_rest_i
);

  logic in_acc;
  assign in_acc = in_valid_i & ~in_stall_i;

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(bar_i) && $stable(peak_i)
      && $stable(at_rest_i))
    else $error("stalled result changed");

  // The held peak never falls below the bar.
  a_peak_ge_bar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> bar_i <= peak_i)
    else $error("peak below bar");

  // The reported peak never exceeds 1.0.
  a_peak_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> peak_i <= Q16_ONE)
    else $error("peak above one");

  // A clear reports zero and full rest once the output is free to take it.
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req_e'(req_type_i) == REQ_CLEAR) ##1 (!out_valid_i || !out_stall_i)
      |=> out_valid_i && bar_i == '0 && peak_i == '0 && at_rest_i)
    else $error("clear result wrong");

endmodule

bind spectrum_bar_peak_hold sbph_checker u_sbph_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .req_type_i  (req_type_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .bar_i       (bar_o),
  .peak_i      (peak_o),
  .at_rest_i   (at_rest_o)
);

FILE: tb/sv/tb_spectrum_bar_peak_hold.sv
// Self-checking bench for the spectrum bar / peak hold meter: drives band
// requests under random idling and back-pressure and checks every reading.
// Depends on sbph_pkg and spectrum_bar_peak_hold.
module tb_spectrum_bar_peak_hold;
  import sbph_pkg::*;

  // Request code that the block must accept but ignore.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [Q16W-1:0] Q16_OVER = 17'h1FFFF;  // widest register value
  localparam int BANDS = BandCountDef;
  localparam int HOLD_CYCLES = 60;                  // long receiver hold-off
  localparam int PHASE_ITEMS = 170;

  typedef struct packed {
    logic [Q16W-1:0] bar;
    logic [Q16W-1:0] peak;
    logic            at_rest;
  } meter_reading_t;

  // Band meter shadow: tracks bars, peaks and registers, queues the reading
  // each accepted request must produce and checks readings in order.
  class meter_scoreboard;
    logic [Q16W-1:0] bar_lvl[BANDS];
    logic [Q16W-1:0] peak_lvl[BANDS];
    logic [Q16W-1:0] reg_val[4];
    meter_reading_t  expected_readings[$];
    int              failures;

    function new();
      foreach (bar_lvl[i]) begin
        bar_lvl[i] = '0;
        peak_lvl[i] = '0;
      end
      reg_val[CFG_BAR_DECAY]  = BAR_DECAY_RST;
      reg_val[CFG_PEAK_DECAY] = PEAK_DECAY_RST;
      reg_val[CFG_REST_DECAY] = REST_DECAY_RST;
      reg_val[CFG_REST_FLOOR] = REST_FLOOR_RST;
      failures = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [Q16W-1:0] value);
      reg_val[idx] = value;
    endfunction

    // Multiply by a Q16 factor capped at one; truncate the fraction.
    function logic [Q16W-1:0] scale(logic [Q16W-1:0] value, logic [Q16W-1:0] factor);
      logic [Q16W-1:0]   f;
      logic [2*Q16W-1:0] prod;
      f = (factor > Q16_ONE) ? Q16_ONE : factor;
      prod = value * f;
      return prod[FracW+Q16W-1:FracW];
    endfunction

    function void note_request(logic [1:0] req, logic [BandW-1:0] band,
                               logic [LevelW-1:0] level);
      logic [Q16W-1:0] incoming;
      logic [Q16W-1:0] new_bar;
      logic [Q16W-1:0] held;
      meter_reading_t  rd;
      case (req)
        REQ_CLEAR: begin
          foreach (bar_lvl[i]) begin
            bar_lvl[i] = '0;
            peak_lvl[i] = '0;
          end
        end
        REQ_APPLY: begin
          // Clamp: negative reads as zero, anything above one as one.
          if (level[LevelW-1]) incoming = '0;
          else if (level > Q16_ONE) incoming = Q16_ONE;
          else incoming = level[Q16W-1:0];
          new_bar = (incoming > bar_lvl[band]) ? incoming
                                               : scale(bar_lvl[band], reg_val[CFG_BAR_DECAY]);
          held = scale(peak_lvl[band], reg_val[CFG_PEAK_DECAY]);
          bar_lvl[band] = new_bar;
          peak_lvl[band] = (new_bar > held) ? new_bar : held;
        end
        REQ_RELEASE: begin
          bar_lvl[band] = scale(bar_lvl[band], reg_val[CFG_REST_DECAY]);
          peak_lvl[band] = scale(peak_lvl[band], reg_val[CFG_REST_DECAY]);
        end
        default: ;  // unused code: state holds
      endcase
      rd.bar = bar_lvl[band];
      rd.peak = peak_lvl[band];
      // At rest only when no band sits above the current floor.
      rd.at_rest = 1'b1;
      foreach (bar_lvl[i]) begin
        if (bar_lvl[i] > reg_val[CFG_REST_FLOOR] || peak_lvl[i] > reg_val[CFG_REST_FLOOR])
          rd.at_rest = 1'b0;
      end
      expected_readings.push_back(rd);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [Q16W-1:0] bar, logic [Q16W-1:0] peak, logic at_rest);
      meter_reading_t want;
      if (expected_readings.size() == 0) begin
        note_failure($sformatf("unexpected reading bar=%0d peak=%0d at_rest=%0b",
                               bar, peak, at_rest));
        return;
      end
      want = expected_readings.pop_front();
      if (want.bar !== bar || want.peak !== peak || want.at_rest !== at_rest)
        note_failure($sformatf({"reading mismatch: expected bar=%0d peak=%0d at_rest=%0b,",
                                " got bar=%0d peak=%0d at_rest=%0b"},
                               want.bar, want.peak, want.at_rest, bar, peak, at_rest));
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         req_type_i;
  logic [BandW-1:0]   band_i;
  logic [LevelW-1:0]  level_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [Q16W-1:0]    bar_o;
  logic [Q16W-1:0]    peak_o;
  logic               at_rest_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [Q16W-1:0]    cfg_wdata_i;

  meter_scoreboard meter_sb;
  bit              idle_on = 1'b1;   // random idling on both sides
  bit              hold_request = 1'b0;
  int              items_sent = 0;

  spectrum_bar_peak_hold uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .band_i      (band_i),
    .level_i     (level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bar_o       (bar_o),
    .peak_o      (peak_o),
    .at_rest_o   (at_rest_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // Offer one request: idle at random first, then hold the payload steady
  // until the block takes it. Drive at the falling edge, sample at the rising.
  task automatic send_request(logic [1:0] req, logic [BandW-1:0] band,
                              logic [LevelW-1:0] level);
    bit taken;
    taken = 1'b0;
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    band_i     <= band;
    level_i    <= level;
    while (!taken) begin
      @(posedge clk_i);
      if (!in_stall_o) taken = 1'b1;
      else @(negedge clk_i);
    end
    meter_sb.note_request(req, band, level);
    items_sent++;
  endtask

  // Write one register; the block is idle whenever this is called.
  task automatic write_reg(cfg_idx_e idx, logic [Q16W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    meter_sb.set_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid and wait until every reading has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (meter_sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Level mix: mostly in range, plus negatives, overshoots and the edges.
  function automatic logic [LevelW-1:0] pick_level();
    int r;
    r = $urandom_range(99);
    if (r < 12) return {1'b1, 18'($urandom)};
    if (r < 22) return LevelW'($urandom_range(262143, 65537));
    if (r < 30) begin
      case ($urandom_range(3))
        0: return '0;
        1: return LevelW'(Q16_ONE);
        2: return LevelW'(65535);
        default: return LevelW'(1);
      endcase
    end
    return LevelW'($urandom_range(65536));
  endfunction

  function automatic logic [Q16W-1:0] pick_factor();
    case ($urandom_range(4))
      0: return '0;
      1: return Q16_ONE;
      2: return Q16_OVER;
      3: return Q16W'($urandom_range(131071));
      default: return Q16W'($urandom_range(65536, 40000));
    endcase
  endfunction

  // Attack, fall and release on one band: the sequence that walks the bar
  // and the peak through their decay paths.
  task automatic run_burst();
    logic [BandW-1:0] b;
    int n;
    b = BandW'($urandom_range(BANDS - 1));
    send_request(REQ_APPLY, b, LevelW'($urandom_range(65536, 20000)));
    n = $urandom_range(6, 1);
    repeat (n) send_request(REQ_APPLY, b, LevelW'($urandom_range(20000)));
    n = $urandom_range(8, 1);
    repeat (n) send_request(REQ_RELEASE, b, pick_level());
  endtask

  // Receiver: stall at random, or hold off for a long counted stretch when
  // asked; check every reading taken at a rising edge.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < 35);
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) meter_sb.check_result(bar_o, peak_o, at_rest_o);
    end
  end

  initial begin
    logic [Q16W-1:0]  cfg_vals[4];
    logic [1:0]       req;
    int               r;
    int               target;
    meter_sb = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_APPLY;
    band_i      = '0;
    level_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_BAR_DECAY;
    cfg_wdata_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset registers, level extremes, every request code.
    send_request(REQ_APPLY, 5'd0, LevelW'(Q16_ONE));
    send_request(REQ_APPLY, 5'd0, '0);               // lower input: bar decays
    send_request(REQ_APPLY, 5'd31, 19'h3FFFF);       // largest positive clamps
    send_request(REQ_APPLY, 5'd31, 19'h40000);       // most negative reads as zero
    send_request(REQ_APPLY, 5'd5, LevelW'(65537));
    send_request(REQ_APPLY, 5'd5, 19'h7FFFF);
    send_request(REQ_APPLY, 5'd5, LevelW'(65535));
    send_request(REQ_RELEASE, 5'd0, '0);
    send_request(REQ_RELEASE, 5'd31, 19'h7FFFF);
    send_request(REQ_RELEASE, 5'd7, '0);             // band never touched
    send_request(REQ_UNUSED, 5'd31, 19'h2AAAA);
    send_request(REQ_UNUSED, 5'd0, 19'h55555);
    send_request(REQ_CLEAR, 5'd9, '0);
    send_request(REQ_APPLY, 5'd3, LevelW'(REST_FLOOR_RST));      // at the floor
    send_request(REQ_APPLY, 5'd3, LevelW'(REST_FLOOR_RST + 1));  // just above
    send_request(REQ_RELEASE, 5'd3, '0);
    send_request(REQ_CLEAR, 5'd31, 19'h7FFFF);
    drain();

    // Zero bar factor, peak factor above one, unity release, zero floor.
    write_reg(CFG_BAR_DECAY, '0);
    write_reg(CFG_PEAK_DECAY, Q16_OVER);
    write_reg(CFG_REST_DECAY, Q16_ONE);
    write_reg(CFG_REST_FLOOR, '0);
    send_request(REQ_APPLY, 5'd1, LevelW'(40000));
    send_request(REQ_APPLY, 5'd1, LevelW'(100));
    send_request(REQ_RELEASE, 5'd1, '0);
    drain();
    // Floor above one: nothing can exceed it.
    write_reg(CFG_REST_FLOOR, Q16_OVER);
    send_request(REQ_APPLY, 5'd2, LevelW'(Q16_ONE));
    drain();
    write_reg(CFG_REST_FLOOR, Q16_ONE);
    send_request(REQ_APPLY, 5'd2, 19'h3FFFF);
    drain();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          cfg_vals[0] = BAR_DECAY_RST;
          cfg_vals[1] = PEAK_DECAY_RST;
          cfg_vals[2] = REST_DECAY_RST;
          cfg_vals[3] = REST_FLOOR_RST;
        end
        1: begin
          cfg_vals[0] = Q16_OVER;
          cfg_vals[1] = Q16_ONE;
          cfg_vals[2] = Q16_OVER;
          cfg_vals[3] = Q16_ONE;
        end
        2: begin
          cfg_vals[0] = '0;
          cfg_vals[1] = '0;
          cfg_vals[2] = '0;
          cfg_vals[3] = '0;
        end
        default: begin
          cfg_vals[0] = pick_factor();
          cfg_vals[1] = pick_factor();
          cfg_vals[2] = pick_factor();
          case ($urandom_range(4))
            0: cfg_vals[3] = '0;
            1: cfg_vals[3] = REST_FLOOR_RST;
            2: cfg_vals[3] = Q16W'($urandom_range(3000));
            3: cfg_vals[3] = Q16_ONE;
            default: cfg_vals[3] = Q16W'($urandom_range(131071));
          endcase
        end
      endcase
      for (int i = 0; i < 4; i++) write_reg(cfg_idx_e'(i), cfg_vals[i]);

      // Run one phase without any idling on either side.
      idle_on = (phase != 2);

      if (phase == 3) begin
        // Hold the receiver off while requests keep coming: fill the block
        // until it stalls its input.
        idle_on = 1'b0;
        hold_request = 1'b1;
        repeat (24) send_request(REQ_APPLY, BandW'($urandom_range(BANDS - 1)), pick_level());
        idle_on = 1'b1;
      end

      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        r = $urandom_range(99);
        if (r < 40) begin
          run_burst();
        end else if (r < 45) begin
          send_request(REQ_CLEAR, BandW'($urandom_range(BANDS - 1)), pick_level());
        end else begin
          r = $urandom_range(99);
          if (r < 55) req = REQ_APPLY;
          else if (r < 85) req = REQ_RELEASE;
          else if (r < 95) req = REQ_UNUSED;
          else req = REQ_CLEAR;
          send_request(req, BandW'($urandom_range(BANDS - 1)), pick_level());
        end
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (meter_sb.pending() != 0)
      meter_sb.note_failure($sformatf("%0d readings never arrived", meter_sb.pending()));
    if (meter_sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sbph_pkg.sv
hw/rtl/sbph_band_mem.sv
hw/rtl/sbph_update.sv
hw/rtl/spectrum_bar_peak_hold.sv
hw/rtl/sbph_checker.sv
tb/sv/tb_spectrum_bar_peak_hold.sv
